// ===== design/mit_pkg.sv =====
// Package for the 4x4 matrix inverse-transpose block: widths, codes, command
// and status structs between controller and datapath, and small helper functions.
// No dependencies; every other design file refers to it by scoped names.
package mit_pkg;

  localparam int ELEM_W      = 32;            // matrix element, signed Q16.16
  localparam int FRAC_BITS   = 16;            // fraction bits of an element
  localparam int ACC_W       = 64;            // Q32.32 working width
  localparam int Q32_SHIFT   = 32 - FRAC_BITS;
  localparam int DIV_STEPS   = ACC_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int IN_DATA_W   = 40;            // 4 + 32 bits, padded to bytes
  localparam int OUT_DATA_W  = 104;           // 4 + 32 + 64 bits, padded to bytes

  typedef logic [3:0] idx_t;

  localparam idx_t IDX_TRIGGER = 4'd15;       // last element; starts the computation
  localparam idx_t IDX_LAST    = 4'd15;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Commands from the controller to the datapath, valid in the current cycle.
  typedef struct packed {
    logic in_ready;
    idx_t mem_addr;
    logic x_ld_elem;
    logic x_ld_res;
    logic mul_mag;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic mul_fin;
    logic acc_add;
    logic acc_sub;
    logic cof_wr;
    logic det_acc;
    logic cof_clr;
    logic run_clr;
    logic cof_rd;
    logic div_start;
    logic out_ld;
    logic out_sing;
    idx_t k;
  } mit_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic in_fire;
    logic in_trig;
    logic det_zero;
    logic div_done;
    logic out_free;
  } mit_sts_t;

  typedef struct packed {
    logic [ACC_W-1:0] val;
    logic             sat;
  } sat_t;

  // Saturating 64-bit add or subtract.
  function automatic sat_t sat_addsub(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b,
                                      input logic sub);
    logic [ACC_W-1:0] r;
    logic             ovf;
    sat_t             res;
    r   = sub ? (a - b) : (a + b);
    ovf = sub ? ((a[ACC_W-1] != b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]))
              : ((a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]));
    res.sat = ovf;
    res.val = ovf ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : r;
    return res;
  endfunction

  function automatic logic [1:0] mod3(input logic [2:0] v);
    logic [2:0] m;
    m = (v >= 3'd3) ? (v - 3'd3) : v;
    return m[1:0];
  endfunction

  // Element position of factor j (0..2) of Sarrus term t (0..5) for the minor
  // that drops row k[1:0] and column k[3:2]. Terms 0..2 add, 3..5 subtract.
  function automatic idx_t elem_idx(input idx_t k, input logic [2:0] t, input logic [1:0] j);
    logic [1:0] row, col, s, rr, cc, r, c;
    logic       neg;
    row = k[1:0];
    col = k[3:2];
    neg = (t >= 3'd3);
    s   = neg ? 2'(t - 3'd3) : t[1:0];
    rr  = j;
    if (j == 2'd0) begin
      cc = s;
    end else if ((j == 2'd1) != neg) begin
      cc = mod3({1'b0, s} + 3'd1);
    end else begin
      cc = mod3({1'b0, s} + 3'd2);
    end
    r = (rr >= row) ? (rr + 2'd1) : rr;
    c = (cc >= col) ? (cc + 2'd1) : cc;
    return {c, r};
  endfunction

endpackage

// ===== design/matrix4_inverse_transpose.sv =====
// Top level of the 4x4 fixed-point matrix inverse-transpose block.
// Depends on mit_pkg, mit_ctrl, mit_dp (which holds mit_div).
//
//   Channel  Direction  Content of one transaction
//   in_      slave      one matrix element and its column-major position
//   out_     master     one inverse-transpose element, determinant and flags
//
// Loading position 15 starts the work: 16 cofactors of six triple products each
// run on the shared 64x32 multiplier; then, unless the determinant is zero, come
// 16 divisions, each of 80 steps of the bit-serial divider plus the cofactor
// read, the start and the output load. A stalled output holds the sequencer
// before the next division. Reset is synchronous and active low; it clears the
// matrix to zeros. The input is taken only while no matrix is in work, and stays
// open while the last result waits in the output register.
module matrix4_inverse_transpose (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, from bit 0: elem_index[3:0], elem_value[35:4], zero pad[39:36]
  input  logic [mit_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, from bit 0: out_index[3:0], out_value[35:4], determinant[99:36],
  // zero pad[103:100]
  output logic [mit_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser, from bit 0: invertible, saturated
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast
);

  mit_pkg::mit_cmd_t cmd;
  mit_pkg::mit_sts_t sts;

  mit_pkg::idx_t                 out_idx;
  logic [31:0]                   out_value;
  logic [mit_pkg::ACC_W-1:0]     out_det;
  logic                          out_inv;
  logic                          out_sat;

  // The controller steps through the cofactor, determinant and division phases.
  mit_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath owns every store, the multiplier, the divider and the output register.
  mit_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_tvalid),
    .in_idx    (in_tdata[3:0]),
    .in_value  (in_tdata[35:4]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_idx   (out_idx),
    .out_value (out_value),
    .out_det   (out_det),
    .out_inv   (out_inv),
    .out_sat   (out_sat),
    .out_last  (out_tlast)
  );

  assign in_tready = cmd.in_ready;
  assign out_tdata = {4'd0, out_det, out_value, out_idx};
  assign out_tuser = {out_sat, out_inv};

`ifndef ASSERT_OFF
  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded over an undelivered transaction");

  // A singular result is a lone, all-zero, final transaction.
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && (out_tdata[99:0] == '0)))
    else $error("singular result malformed");

  // Starting a division clears its done flag.
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider reports done right after start");

  // The input is not open when a division starts.
  a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !in_tready)
    else $error("input open during division");
`endif

endmodule

// ===== design/mit_div.sv =====
// Bit-serial restoring divider: (num * 2^FRAC_BITS) / den on magnitudes,
// truncated toward zero and clipped to a signed 32-bit result. Uses mit_pkg.
module mit_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mit_pkg::ACC_W-1:0] num,
  input  logic [mit_pkg::ACC_W-1:0] den,
  output logic                      done,
  output logic [31:0]               quo,
  output logic                      sat
);

  localparam int NUM_W = mit_pkg::DIV_STEPS;

  logic [NUM_W-1:0]              nm_r;
  logic [mit_pkg::ACC_W-1:0]     d_r;
  logic [mit_pkg::ACC_W-1:0]     rem_r;
  logic [32:0]                   q_r;
  logic                          ovf_r;
  logic                          neg_r;
  logic                          busy_r;
  logic                          done_r;
  logic [mit_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [mit_pkg::ACC_W:0]   trial;
  logic [mit_pkg::ACC_W:0]   diff;
  logic                      ge;
  logic [mit_pkg::ACC_W-1:0] num_mag;
  logic [mit_pkg::ACC_W-1:0] den_mag;
  logic [32:0]               lim;
  logic [32:0]               clipped;
  logic                      over;

  assign num_mag = num[mit_pkg::ACC_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[mit_pkg::ACC_W-1] ? (~den + 1'b1) : den;
  assign trial   = {rem_r, nm_r[NUM_W-1]};
  assign diff    = trial - {1'b0, d_r};
  assign ge      = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == mit_pkg::DIV_CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nm_r  <= {num_mag, {mit_pkg::FRAC_BITS{1'b0}}};
      d_r   <= den_mag;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= num[mit_pkg::ACC_W-1] ^ den[mit_pkg::ACC_W-1];
    end else if (busy_r) begin
      nm_r  <= {nm_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[mit_pkg::ACC_W-1:0] : trial[mit_pkg::ACC_W-1:0];
      ovf_r <= ovf_r | q_r[32];
      q_r   <= {q_r[31:0], ge};
    end
  end

  // Clip the magnitude to 2^31 for a negative result and 2^31-1 otherwise.
  assign lim     = neg_r ? 33'h080000000 : 33'h07FFFFFFF;
  assign over    = ovf_r || (q_r > lim);
  assign clipped = over ? lim : q_r;
  assign quo     = neg_r ? 32'(~clipped + 1'b1) : clipped[31:0];
  assign sat     = over;
  assign done    = done_r;

endmodule

// ===== design/mit_dp.sv =====
// Datapath of the inverse-transpose block: matrix and cofactor stores, shared
// 64x32 multiplier, accumulators, divider and output register. Uses mit_pkg, mit_div.
module mit_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mit_pkg::mit_cmd_t              cmd,
  output mit_pkg::mit_sts_t              sts,
  input  logic                           in_valid,
  input  mit_pkg::idx_t                  in_idx,
  input  logic [mit_pkg::ELEM_W-1:0]     in_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output mit_pkg::idx_t                  out_idx,
  output logic [31:0]                    out_value,
  output logic [mit_pkg::ACC_W-1:0]      out_det,
  output logic                           out_inv,
  output logic                           out_sat,
  output logic                           out_last
);

  localparam int W      = mit_pkg::ACC_W;
  localparam int EW     = mit_pkg::ELEM_W;
  localparam int PROD_W = W + 32;
  localparam int SH_W   = PROD_W + 1 - mit_pkg::FRAC_BITS;

  // Matrix store with valid bits so that reset reads back zeros.
  logic [EW-1:0] mat_mem [16];
  logic [15:0]   mval_r;
  logic [EW-1:0] rd_r;
  logic          in_fire;

  assign in_fire = in_valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mval_r <= '0;
    end else if (in_fire) begin
      mval_r[in_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mat_mem[in_idx] <= in_value;
    end
    rd_r <= mval_r[cmd.mem_addr] ? mat_mem[cmd.mem_addr] : '0;
  end

  // Multiplier: sign-magnitude, two 32x32 partial products, then floor shift.
  logic [W-1:0]      x_r;
  logic [W-1:0]      mx_r;
  logic [31:0]       my_r;
  logic              neg_r;
  logic [63:0]       plo_r;
  logic [63:0]       phi_r;
  logic [PROD_W-1:0] prod_r;
  logic [W-1:0]      res_r;
  logic              res_sat_r;

  logic [W-1:0]      elem_q32;
  logic [PROD_W:0]   prod_ext;
  logic [PROD_W:0]   signed_prod;
  logic [SH_W-1:0]   shifted;
  logic              fin_sat;

  assign elem_q32    = W'(signed'(rd_r)) << mit_pkg::Q32_SHIFT;
  assign prod_ext    = {1'b0, prod_r};
  assign signed_prod = neg_r ? (~prod_ext + 1'b1) : prod_ext;
  assign shifted     = signed_prod[PROD_W:mit_pkg::FRAC_BITS];
  assign fin_sat     = !((&shifted[SH_W-1:W-1]) || !(|shifted[SH_W-1:W-1]));

  // Accumulators.
  logic [W-1:0] acc_r;
  logic         csat_r;
  logic [W-1:0] det_r;
  logic         dsat_r;

  mit_pkg::sat_t acc_nxt;
  mit_pkg::sat_t det_nxt;
  logic [W-1:0]  cof_val;
  logic          cof_negsat;
  logic          odd;

  assign acc_nxt    = mit_pkg::sat_addsub(acc_r, res_r, cmd.acc_sub);
  assign det_nxt    = mit_pkg::sat_addsub(det_r, res_r, 1'b0);
  assign odd        = cmd.k[0] ^ cmd.k[2];
  assign cof_negsat = odd && (acc_r == mit_pkg::ACC_MIN);
  assign cof_val    = !odd ? acc_r : (cof_negsat ? mit_pkg::ACC_MAX : (~acc_r + 1'b1));

  always_ff @(posedge clk) begin
    if (cmd.x_ld_elem) begin
      x_r <= elem_q32;
    end else if (cmd.x_ld_res) begin
      x_r <= res_r;
    end else if (cmd.cof_wr) begin
      x_r <= cof_val;
    end
    if (cmd.mul_mag) begin
      mx_r  <= x_r[W-1] ? (~x_r + 1'b1) : x_r;
      my_r  <= rd_r[EW-1] ? 32'(~rd_r + 1'b1) : 32'(rd_r);
      neg_r <= x_r[W-1] ^ rd_r[EW-1];
    end
    if (cmd.mul_lo) begin
      plo_r <= mx_r[31:0] * my_r;
    end
    if (cmd.mul_hi) begin
      phi_r <= mx_r[W-1:32] * my_r;
    end
    if (cmd.mul_sum) begin
      prod_r <= {phi_r, 32'd0} + {32'd0, plo_r};
    end
    if (cmd.mul_fin) begin
      res_sat_r <= fin_sat;
      res_r     <= fin_sat ? (shifted[SH_W-1] ? mit_pkg::ACC_MIN : mit_pkg::ACC_MAX)
                           : shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      csat_r <= 1'b0;
      det_r  <= '0;
      dsat_r <= 1'b0;
    end else if (cmd.run_clr) begin
      acc_r  <= '0;
      csat_r <= 1'b0;
      det_r  <= '0;
      dsat_r <= 1'b0;
    end else begin
      if (cmd.acc_add || cmd.acc_sub) begin
        acc_r  <= acc_nxt.val;
        csat_r <= csat_r | acc_nxt.sat | res_sat_r;
      end else if (cmd.x_ld_res) begin
        // The first product of a triple can clip too.
        csat_r <= csat_r | res_sat_r;
      end else if (cmd.cof_wr) begin
        csat_r <= csat_r | cof_negsat;
      end else if (cmd.cof_clr) begin
        acc_r  <= '0;
        csat_r <= 1'b0;
      end
      if (cmd.det_acc) begin
        det_r  <= det_nxt.val;
        dsat_r <= dsat_r | csat_r | res_sat_r | det_nxt.sat;
      end
    end
  end

  // Cofactor store: value with its clip flag in the top bit.
  logic [W:0] cof_mem [16];
  logic [W:0] cof_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.cof_wr) begin
      cof_mem[cmd.k] <= {csat_r | cof_negsat, cof_val};
    end
    if (cmd.cof_rd) begin
      cof_rd_r <= cof_mem[cmd.k];
    end
  end

  logic        div_done;
  logic [31:0] div_quo;
  logic        div_sat;

  mit_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cof_rd_r[W-1:0]),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // Output register.
  logic          out_valid_r;
  mit_pkg::idx_t out_idx_r;
  logic [31:0]   out_value_r;
  logic [W-1:0]  out_det_r;
  logic          out_inv_r;
  logic          out_sat_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      if (cmd.out_sing) begin
        out_idx_r   <= '0;
        out_value_r <= '0;
        out_det_r   <= '0;
        out_inv_r   <= 1'b0;
        out_sat_r   <= dsat_r;
        out_last_r  <= 1'b1;
      end else begin
        out_idx_r   <= cmd.k;
        out_value_r <= div_quo;
        out_det_r   <= det_r;
        out_inv_r   <= 1'b1;
        out_sat_r   <= dsat_r | cof_rd_r[W] | div_sat;
        out_last_r  <= (cmd.k == mit_pkg::IDX_LAST);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_value = out_value_r;
  assign out_det   = out_det_r;
  assign out_inv   = out_inv_r;
  assign out_sat   = out_sat_r;
  assign out_last  = out_last_r;

  assign sts.in_fire  = in_fire;
  assign sts.in_trig  = (in_idx == mit_pkg::IDX_TRIGGER);
  assign sts.det_zero = (det_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ===== design/mit_ctrl.sv =====
// Controller of the inverse-transpose block: sequences loads, Sarrus products,
// determinant, divisions and result delivery. Uses mit_pkg command and status types.
module mit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  mit_pkg::mit_sts_t sts,
  output mit_pkg::mit_cmd_t cmd
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_RDA  = 19'h00002,
    S_LDA  = 19'h00004,
    S_MAG  = 19'h00008,
    S_LO   = 19'h00010,
    S_HI   = 19'h00020,
    S_SUM  = 19'h00040,
    S_FIN  = 19'h00080,
    S_RDC  = 19'h00100,
    S_ACC  = 19'h00200,
    S_SIGN = 19'h00400,
    S_DACC = 19'h00800,
    S_NEXT = 19'h01000,
    S_QCHK = 19'h02000,
    S_QRD  = 19'h04000,
    S_QST  = 19'h08000,
    S_QWT  = 19'h10000,
    S_QOUT = 19'h20000,
    S_SING = 19'h40000
  } state_t;

  // Which multiply is in flight: second factor, third factor, determinant term.
  typedef enum logic [2:0] {
    MP_B   = 3'b001,
    MP_C   = 3'b010,
    MP_DET = 3'b100
  } mpass_t;

  state_t        state_r, state_nxt;
  mpass_t        mp_r, mp_nxt;
  mit_pkg::idx_t k_r, k_nxt;
  logic [2:0]    t_r, t_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mp_r    <= MP_B;
      k_r     <= '0;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      mp_r    <= mp_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mp_nxt    = mp_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    cmd       = '0;
    cmd.k     = k_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire && sts.in_trig) begin
          cmd.run_clr = 1'b1;
          k_nxt       = '0;
          t_nxt       = '0;
          state_nxt   = S_RDA;
        end
      end
      S_RDA: begin
        cmd.mem_addr = mit_pkg::elem_idx(k_r, t_r, 2'd0);
        state_nxt    = S_LDA;
      end
      S_LDA: begin
        cmd.x_ld_elem = 1'b1;
        cmd.mem_addr  = mit_pkg::elem_idx(k_r, t_r, 2'd1);
        mp_nxt        = MP_B;
        state_nxt     = S_MAG;
      end
      S_MAG: begin
        cmd.mul_mag = 1'b1;
        state_nxt   = S_LO;
      end
      S_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_HI;
      end
      S_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.mul_sum = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.mul_fin = 1'b1;
        case (mp_r)
          MP_B:    state_nxt = S_RDC;
          MP_C:    state_nxt = S_ACC;
          MP_DET:  state_nxt = S_DACC;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RDC: begin
        cmd.x_ld_res = 1'b1;
        cmd.mem_addr = mit_pkg::elem_idx(k_r, t_r, 2'd2);
        mp_nxt       = MP_C;
        state_nxt    = S_MAG;
      end
      S_ACC: begin
        cmd.acc_add = (t_r < 3'd3);
        cmd.acc_sub = (t_r >= 3'd3);
        if (t_r == 3'd5) begin
          state_nxt = S_SIGN;
        end else begin
          t_nxt     = t_r + 3'd1;
          state_nxt = S_RDA;
        end
      end
      S_SIGN: begin
        cmd.cof_wr   = 1'b1;
        cmd.mem_addr = k_r;
        if (k_r[3:2] == 2'd0) begin
          mp_nxt    = MP_DET;
          state_nxt = S_MAG;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DACC: begin
        cmd.det_acc = 1'b1;
        state_nxt   = S_NEXT;
      end
      S_NEXT: begin
        cmd.cof_clr = 1'b1;
        t_nxt       = '0;
        if (k_r == mit_pkg::IDX_LAST) begin
          k_nxt     = '0;
          state_nxt = S_QCHK;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_RDA;
        end
      end
      S_QCHK: begin
        state_nxt = sts.det_zero ? S_SING : S_QRD;
      end
      S_QRD: begin
        cmd.cof_rd = 1'b1;
        state_nxt  = S_QST;
      end
      S_QST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_QWT;
      end
      S_QWT: begin
        if (sts.div_done) begin
          state_nxt = S_QOUT;
        end
      end
      S_QOUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          if (k_r == mit_pkg::IDX_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_QRD;
          end
        end
      end
      S_SING: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sing = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
